>>> design/bfu_pkg.sv
package bfu_pkg;

  // Store geometry.
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FSW   = AW + 1;

  localparam logic [AW-1:0]  LAST_POS   = AW'(DEPTH - 1);
  localparam logic [FSW-1:0] DEPTH_W    = FSW'(DEPTH);
  localparam logic [FSW-1:0] FULL_GUARD = FSW'(2);

  // Operation codes. The fourth code has no operation behind it.
  localparam int unsigned OPW = 2;
  localparam logic [OPW-1:0] OP_PUSH   = 2'd0;
  localparam logic [OPW-1:0] OP_POP    = 2'd1;
  localparam logic [OPW-1:0] OP_QUERY  = 2'd2;
  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CIW = 2;
  localparam logic [CIW-1:0] CFG_ESCAPE  = 2'd0;
  localparam logic [CIW-1:0] CFG_STUFF_A = 2'd1;
  localparam logic [CIW-1:0] CFG_STUFF_B = 2'd2;

  // Write and read requests to the byte store.
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
  } store_req_t;

endpackage

>>> design/bfu_ifs.sv
interface bfu_req_if;
  logic                       valid;
  logic                       ready;
  logic [bfu_pkg::OPW-1:0]    opcode;
  logic [7:0]                 push_byte;

  modport source (output valid, output opcode, output push_byte, input ready);
  modport sink   (input valid, input opcode, input push_byte, output ready);
endinterface

interface bfu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [7:0]                 pop_byte;
  logic                       was_dropped;
  logic [bfu_pkg::FSW-1:0]    free_space;
  logic [bfu_pkg::FSW-1:0]    free_low_mark;
  logic [31:0]                overflow_total;
  logic                       is_empty;

  modport source (output valid, output ok, output pop_byte, output was_dropped,
                  output free_space, output free_low_mark, output overflow_total,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input pop_byte, input was_dropped,
                  input free_space, input free_low_mark, input overflow_total,
                  input is_empty, output ready);
endinterface

interface bfu_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bfu_pkg::CIW-1:0]    index;
  logic [7:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bfu_store.sv
// Byte store: one write port, one registered read port, and a copy of the
// byte written most recently.
module bfu_store (
  input  logic                clk,
  input  bfu_pkg::store_req_t req,
  output logic [7:0]          rd_data,
  output logic [7:0]          last_byte
);

  logic [7:0] mem [bfu_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
      last_byte        <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> design/byte_fifo_with_unstuffing.sv
// A transaction is accepted into the work stage, where the byte store is read,
// and its result is registered in the output register once that is free. A new
// transaction is taken only when the work stage is empty, since the store data
// for an item is used after it is accepted; a stalled result holds the input.
// Reset (synchronous, rst high) empties the FIFO, sets the low-watermark to the
// depth, clears the overflow count and the three code registers; bytes stay.
module byte_fifo_with_unstuffing (
  input  logic       clk,
  input  logic       rst,
  bfu_req_if.sink    req,
  bfu_rsp_if.source  rsp,
  bfu_cfg_if.sink    cfg
);

  // Configuration registers. Writes must be made only while the block is idle,
  // which the block does not enforce; outside reset they are always accepted.
  logic [7:0] escape_code;
  logic [7:0] stuff_code_a;
  logic [7:0] stuff_code_b;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code  <= '0;
      stuff_code_a <= '0;
      stuff_code_b <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        bfu_pkg::CFG_ESCAPE:  escape_code  <= cfg.data;
        bfu_pkg::CFG_STUFF_A: stuff_code_a <= cfg.data;
        bfu_pkg::CFG_STUFF_B: stuff_code_b <= cfg.data;
        default: ;
      endcase
    end
  end

  // FIFO pointers and statistics.
  logic [bfu_pkg::AW-1:0]  read_pos,  read_pos_next;
  logic [bfu_pkg::AW-1:0]  write_pos, write_pos_next;
  logic [bfu_pkg::FSW-1:0] low_mark,  low_mark_next;
  logic [31:0]             overflow_count, overflow_count_next;

  // The single work stage. An accepted transaction waits here while the store
  // is read at the read position; it is then resolved and moved into the output
  // register once that register is free.
  logic                    work_valid;
  logic [bfu_pkg::OPW-1:0] work_op;
  logic [7:0]              work_byte;

  logic req_fire;
  logic work_fire;
  logic out_free;

  assign out_free   = !rsp.valid || rsp.ready;
  assign work_fire  = work_valid && out_free;
  assign req.ready  = !work_valid && !rst;
  assign req_fire   = req.valid && req.ready;

  // Byte store. The read for a pop is issued on every acceptance; the pointers
  // cannot move before the work stage uses the data, so no forwarding is needed.
  bfu_pkg::store_req_t store_req;
  logic [7:0]          rd_data;
  logic [7:0]          last_byte;

  bfu_store u_store (
    .clk       (clk),
    .req       (store_req),
    .rd_data   (rd_data),
    .last_byte (last_byte)
  );

  // Occupancy of a pair of positions, as free entries.
  function automatic logic [bfu_pkg::FSW-1:0] free_of(
    input logic [bfu_pkg::AW-1:0] rp,
    input logic [bfu_pkg::AW-1:0] wp
  );
    logic [bfu_pkg::FSW-1:0] used;
    if (wp >= rp) begin
      used = {1'b0, wp} - {1'b0, rp};
    end else begin
      used = bfu_pkg::DEPTH_W + {1'b0, wp} - {1'b0, rp};
    end
    return bfu_pkg::DEPTH_W - used;
  endfunction

  function automatic logic [bfu_pkg::AW-1:0] pos_step(input logic [bfu_pkg::AW-1:0] p);
    return (p == bfu_pkg::LAST_POS) ? '0 : p + 1'b1;
  endfunction

  logic [bfu_pkg::FSW-1:0] free_before;
  logic                    non_empty;
  logic                    is_stuff;
  logic                    res_ok;
  logic [7:0]              res_pop;
  logic                    res_dropped;
  logic                    do_store;

  always_comb begin
    free_before         = free_of(read_pos, write_pos);
    non_empty           = read_pos != write_pos;
    is_stuff            = (work_byte == stuff_code_a) || (work_byte == stuff_code_b);
    read_pos_next       = read_pos;
    write_pos_next      = write_pos;
    low_mark_next       = low_mark;
    overflow_count_next = overflow_count;
    res_ok              = 1'b0;
    res_pop             = '0;
    res_dropped         = 1'b0;
    do_store            = 1'b0;

    case (work_op)
      bfu_pkg::OP_PUSH: begin
        if (free_before < low_mark) begin
          low_mark_next = free_before;
        end
        if (free_before < bfu_pkg::FULL_GUARD) begin
          overflow_count_next = overflow_count + 32'd1;
        end else begin
          res_ok = 1'b1;
          // A stuffing byte is dropped unless the FIFO is empty, the byte is
          // itself the escape code, or the last stored byte escapes it.
          if (non_empty && is_stuff && work_byte != escape_code &&
              last_byte != escape_code) begin
            res_dropped = 1'b1;
          end else begin
            do_store       = 1'b1;
            write_pos_next = pos_step(write_pos);
          end
        end
      end
      bfu_pkg::OP_POP: begin
        if (non_empty) begin
          res_ok        = 1'b1;
          res_pop       = rd_data;
          read_pos_next = pos_step(read_pos);
        end
      end
      bfu_pkg::OP_QUERY: begin
        res_ok = 1'b1;
        if (free_before < low_mark) begin
          low_mark_next = free_before;
        end
      end
      default: ;
    endcase

    store_req.wr_en   = work_fire && do_store;
    store_req.wr_addr = write_pos;
    store_req.wr_data = work_byte;
    store_req.rd_en   = req_fire;
    store_req.rd_addr = read_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid     <= 1'b0;
      read_pos       <= '0;
      write_pos      <= '0;
      low_mark       <= bfu_pkg::DEPTH_W;
      overflow_count <= '0;
    end else begin
      if (req_fire) begin
        work_valid <= 1'b1;
      end else if (work_fire) begin
        work_valid <= 1'b0;
      end
      if (work_fire) begin
        read_pos       <= read_pos_next;
        write_pos      <= write_pos_next;
        low_mark       <= low_mark_next;
        overflow_count <= overflow_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      work_op   <= req.opcode;
      work_byte <= req.push_byte;
    end
  end

  // Output register: holds a finished result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (work_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work_fire) begin
      rsp.ok             <= res_ok;
      rsp.pop_byte       <= res_pop;
      rsp.was_dropped    <= res_dropped;
      rsp.free_space     <= free_of(read_pos_next, write_pos_next);
      rsp.free_low_mark  <= low_mark_next;
      rsp.overflow_total <= overflow_count_next;
      rsp.is_empty       <= read_pos_next == write_pos_next;
    end
  end

endmodule

>>> design/bfu_checker.sv
module bfu_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    ok,
  input logic [7:0]              pop_byte,
  input logic                    was_dropped,
  input logic [bfu_pkg::FSW-1:0] free_space,
  input logic                    is_empty
);

  // A result that is not taken stays offered with the same pop byte and ok flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_byte) && $stable(ok))
    else $error("result changed while stalled");

  // A dropped byte is a successful push and returns no data.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_dropped |-> ok && pop_byte == 8'd0)
    else $error("dropped byte reported inconsistently");

  // A failed operation returns no data.
  a_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ok |-> pop_byte == 8'd0 && !was_dropped)
    else $error("failed operation returned data");

  // An empty FIFO has the whole depth free, and only an empty one has.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> is_empty == (free_space == bfu_pkg::DEPTH_W))
    else $error("empty flag and free space disagree");

endmodule

bind byte_fifo_with_unstuffing bfu_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .ok          (rsp.ok),
  .pop_byte    (rsp.pop_byte),
  .was_dropped (rsp.was_dropped),
  .free_space  (rsp.free_space),
  .is_empty    (rsp.is_empty)
);
